// ===== rtl/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon test
// Default widths, queue depths and the control word that goes with each
// vertex from the front part to the back part.
// ----------------------------------------------------------------------------
package pip_pkg;

  // default coordinate width (longitude; latitude is one bit narrower)
  localparam int COORD_BITS_DEF = 32;

  // depth of the queue between the front and the back part
  localparam int EDGE_QUEUE_DEPTH = 4;

  // depth of the result queue
  localparam int RES_QUEUE_DEPTH = 2;

  // control word for one vertex: polygon flags and the flags of both edge tests
  typedef struct packed {
    logic first;      // vertex opens a new polygon, parity restarts
    logic last;       // vertex closes the polygon, a result follows
    logic straddle1;  // edge from previous vertex straddles the point
    logic bneg1;      // longitude span of that edge is negative
    logic straddle2;  // closing edge straddles the point
    logic bneg2;      // longitude span of the closing edge is negative
  } edge_ctrl_t;

endpackage

// ===== rtl/pip_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_fifo: small register queue
// Push and pop in the same cycle are allowed; the oldest word is shown on
// rdata while empty is low.
// ----------------------------------------------------------------------------
module pip_fifo import pip_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = RES_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // advance pointers and fill count
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pip_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_front: vertex intake and edge classification
// Tracks the held point, first and previous vertex, forms the differences
// of both edge tests and their straddle flags, and pushes one word per
// vertex into the edge queue.
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic signed [COORD_BITS-2:0] point_lat,
  input  logic signed [COORD_BITS-1:0] point_lon,
  input  logic signed [COORD_BITS-2:0] vertex_lat,
  input  logic signed [COORD_BITS-1:0] vertex_lon,
  input  logic                         last_vertex,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [$bits(edge_ctrl_t)+8*COORD_BITS+3:0] q_data
);

  localparam int W  = COORD_BITS;
  localparam int LW = COORD_BITS - 1;
  localparam int DW = COORD_BITS + 1;

  logic signed [LW-1:0] held_lat_r, first_lat_r, prev_lat_r;
  logic signed [W-1:0]  held_lon_r, first_lon_r, prev_lon_r;
  logic                 in_poly_r, in_poly_nxt;

  logic                 is_first;
  logic signed [LW-1:0] held_lat, first_lat, prev_lat;
  logic signed [W-1:0]  held_lon, first_lon, prev_lon;
  logic signed [W-1:0]  a1, c1, a2, c2;
  logic signed [DW-1:0] b1, d1, b2, d2;
  edge_ctrl_t           ctrl;

  assign is_first = !in_poly_r;
  assign q_push   = push && !q_full;

  // pick the live point and the edge ends
  always_comb begin
    held_lat  = is_first ? point_lat  : held_lat_r;
    held_lon  = is_first ? point_lon  : held_lon_r;
    first_lat = is_first ? vertex_lat : first_lat_r;
    first_lon = is_first ? vertex_lon : first_lon_r;
    prev_lat  = is_first ? vertex_lat : prev_lat_r;
    prev_lon  = is_first ? vertex_lon : prev_lon_r;
  end

  // edge from current vertex (i) to previous vertex (j)
  always_comb begin
    a1 = W'(held_lat) - W'(vertex_lat);
    b1 = DW'(prev_lon) - DW'(vertex_lon);
    c1 = W'(prev_lat) - W'(vertex_lat);
    d1 = DW'(held_lon) - DW'(vertex_lon);
  end

  // closing edge from first vertex (i) to current vertex (j)
  always_comb begin
    a2 = W'(held_lat) - W'(first_lat);
    b2 = DW'(vertex_lon) - DW'(first_lon);
    c2 = W'(vertex_lat) - W'(first_lat);
    d2 = DW'(held_lon) - DW'(first_lon);
  end

  // classify both edges
  always_comb begin
    ctrl.first     = is_first;
    ctrl.last      = last_vertex;
    ctrl.straddle1 = (vertex_lon > held_lon) != (prev_lon > held_lon);
    ctrl.bneg1     = b1[DW-1];
    ctrl.straddle2 = last_vertex && ((first_lon > held_lon) != (vertex_lon > held_lon));
    ctrl.bneg2     = b2[DW-1];
  end

  assign q_data = {ctrl, a1, b1, c1, d1, a2, b2, c2, d2};

  assign in_poly_nxt = q_push ? !last_vertex : in_poly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_poly_r <= 1'b0;
    end else begin
      in_poly_r <= in_poly_nxt;
    end
  end

  // latch point and vertices on each accepted word
  always_ff @(posedge clk) begin
    if (q_push) begin
      if (is_first) begin
        held_lat_r  <= point_lat;
        held_lon_r  <= point_lon;
        first_lat_r <= vertex_lat;
        first_lon_r <= vertex_lon;
      end
      prev_lat_r <= vertex_lat;
      prev_lon_r <= vertex_lon;
    end
  end

endmodule

// ===== rtl/pip_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_back: cross-multiply, compare and parity
// Three-step pipeline per vertex: split partial products, full products,
// then sign-corrected compare with parity update and result push.
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  logic [$bits(edge_ctrl_t)+8*COORD_BITS+3:0] q_data,
  output logic q_pop,
  input  logic res_full,
  output logic res_push,
  output logic res_bit
);

  localparam int W   = COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int H   = DW / 2;
  localparam int HW  = DW - H;
  localparam int LPW = W + H + 1;
  localparam int HPW = W + HW;
  localparam int PW  = 2 * W + 1;
  localparam int EW  = 4 * W + 2;
  localparam int CW  = $bits(edge_ctrl_t);

  edge_ctrl_t           q_ctrl;
  logic [EW-1:0]        e1, e2;
  logic signed [W-1:0]  mx [4];
  logic signed [DW-1:0] my [4];

  logic signed [HPW-1:0] p_hi_r [4];
  logic signed [HPW-1:0] p_hi_nxt [4];
  logic signed [LPW-1:0] p_lo_r [4];
  logic signed [LPW-1:0] p_lo_nxt [4];
  logic signed [PW-1:0]  prod_r [4];
  logic signed [PW-1:0]  prod_nxt [4];

  edge_ctrl_t s1_ctrl_r, s2_ctrl_r;
  logic       s1_v_r, s2_v_r;
  logic       parity_r, parity_nxt;
  logic       en, flip1, flip2, par_acc;

  // unpack the edge word
  assign q_ctrl = q_data[CW+2*EW-1 -: CW];
  assign e1     = q_data[2*EW-1 -: EW];
  assign e2     = q_data[EW-1:0];

  // operand pairs: a*b and c*d of both edges
  always_comb begin
    mx[0] = e1[4*W+1 -: W];
    my[0] = e1[3*W+1 -: DW];
    mx[1] = e1[2*W   -: W];
    my[1] = e1[W     -: DW];
    mx[2] = e2[4*W+1 -: W];
    my[2] = e2[3*W+1 -: DW];
    mx[3] = e2[2*W   -: W];
    my[3] = e2[W     -: DW];
  end

  // split the wide factor into a signed upper and unsigned lower half
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_hi_nxt[k] = mx[k] * $signed(my[k][DW-1:H]);
      p_lo_nxt[k] = mx[k] * $signed({1'b0, my[k][H-1:0]});
    end
  end

  // recombine the halves into exact products
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = (PW'(p_hi_r[k]) <<< H) + PW'(p_lo_r[k]);
    end
  end

  // sign-corrected crossing test and parity
  always_comb begin
    flip1 = s2_ctrl_r.straddle1 &&
            (s2_ctrl_r.bneg1 ? (prod_r[1] < prod_r[0]) : (prod_r[0] < prod_r[1]));
    flip2 = s2_ctrl_r.straddle2 &&
            (s2_ctrl_r.bneg2 ? (prod_r[3] < prod_r[2]) : (prod_r[2] < prod_r[3]));
    par_acc = (s2_ctrl_r.first ? 1'b0 : parity_r) ^ flip1 ^ flip2;
  end

  // hold the pipeline while a result waits on a full queue
  assign en         = !(s2_v_r && s2_ctrl_r.last && res_full);
  assign q_pop      = en && !q_empty;
  assign res_push   = s2_v_r && s2_ctrl_r.last && !res_full;
  assign res_bit    = par_acc;
  assign parity_nxt = (s2_v_r && en) ? par_acc : parity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      parity_r <= 1'b0;
    end else if (en) begin
      s1_v_r   <= !q_empty;
      s2_v_r   <= s1_v_r;
      parity_r <= parity_nxt;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctrl_r <= q_ctrl;
      s2_ctrl_r <= s1_ctrl_r;
      for (int k = 0; k < 4; k++) begin
        p_hi_r[k] <= p_hi_nxt[k];
        p_lo_r[k] <= p_lo_nxt[k];
        prod_r[k] <= prod_nxt[k];
      end
    end
  end

endmodule

// ===== rtl/point_in_polygon_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test: ray-casting geofence test
// Streams polygon vertices and reports whether the test point is inside.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: present one vertex word per cycle on the in_ ports and raise
//   in_push; the word is taken at a rising edge with in_push high and in_full
//   low. The test point is sampled with the first vertex of each polygon and
//   ignored afterwards. in_last_vertex marks the closing vertex.
//   Result queue: one word per polygon, out_inside_res, is shown while
//   out_empty is low and taken at an edge with out_pop high.
//   Throughput: one vertex per cycle while in_full is low; both edge tests of
//   a vertex run in parallel in a three-step multiply/compare pipeline.
//   Path: after the closing vertex is taken, its word passes the edge queue,
//   the partial products, the full products and then the compare.
//   Stall: when the result queue is full and a result is due, the back
//   pipeline holds; the edge queue then fills and in_full rises.
//   Reset: synchronous, active low; queues empty, next vertex opens a polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [COORD_BITS-2:0] in_point_lat,
  input  logic signed [COORD_BITS-1:0] in_point_lon,
  input  logic signed [COORD_BITS-2:0] in_vertex_lat,
  input  logic signed [COORD_BITS-1:0] in_vertex_lon,
  input  logic                         in_last_vertex,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_inside_res
);

  localparam int QW = $bits(edge_ctrl_t) + 8 * COORD_BITS + 4;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          res_push, res_full, res_bit;

  assign in_full = q_full;

  // front: intake and classification
  pip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .point_lat  (in_point_lat),
    .point_lon  (in_point_lon),
    .vertex_lat (in_vertex_lat),
    .vertex_lon (in_vertex_lon),
    .last_vertex(in_last_vertex),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // queue between front and back
  pip_fifo #(
    .WIDTH(QW),
    .DEPTH(EDGE_QUEUE_DEPTH)
  ) u_edge_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // back: products, compare, parity
  pip_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res_bit (res_bit)
  );

  // result queue
  pip_fifo #(
    .WIDTH(1),
    .DEPTH(RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_bit),
    .full (res_full),
    .pop  (out_pop),
    .rdata(out_inside_res),
    .empty(out_empty)
  );

`ifndef SYNTHESIS
  // back pipeline never pushes into a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a result shows up only after the back part produced one
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(res_push))
    else $error("result appeared without a push");

  // reset leaves the result queue empty
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> out_empty)
    else $error("result queue not empty after reset");
`endif

endmodule

// ===== dv/point_in_polygon_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb: self-checking bench for the geofence test
// Streams polygons through the vertex queue. A scoreboard predicts the
// crossing parity per polygon with exact wide products. Each inside word
// popped from the result queue is compared with the oldest prediction. Both
// sides idle at random, and the receiver holds off for a long stretch twice.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;
  import pip_pkg::*;

  localparam int CB = COORD_BITS_DEF;

  typedef logic signed [CB-2:0] lat_t;
  typedef logic signed [CB-1:0] lon_t;

  localparam lat_t LAT_TOP = {1'b0, {(CB - 2){1'b1}}};
  localparam lat_t LAT_BOT = {1'b1, {(CB - 2){1'b0}}};
  localparam lon_t LON_TOP = {1'b0, {(CB - 1){1'b1}}};
  localparam lon_t LON_BOT = {1'b1, {(CB - 1){1'b0}}};
  localparam longint LAT_SPAN = 900000000;
  localparam longint LON_SPAN = 1800000000;
  localparam int N_ITEMS = 1100;
  localparam int IDLE_PCT = 14;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;

  // --------------------------------------------------------------------------
  // scoreboard: crossing-parity predictor and queue of inside words
  // --------------------------------------------------------------------------
  class geofence_scoreboard;
    longint first_lat, first_lon, prev_lat, prev_lon, pt_lat, pt_lon;
    bit parity;
    bit open_poly;
    bit inside_q[$];
    int mismatches;

    function new();
      first_lat = 0; first_lon = 0;
      prev_lat = 0; prev_lon = 0;
      pt_lat = 0; pt_lon = 0;
      parity = 1'b0;
      open_poly = 1'b0;
      mismatches = 0;
    endfunction

    // 1 when edge (i, j) straddles the point longitude and passes above it
    function bit edge_crosses(longint lat_i, longint lon_i, longint lat_j, longint lon_j);
      logic signed [127:0] a, b, c, d, ab, cd;
      if ((lon_i > pt_lon) == (lon_j > pt_lon)) return 1'b0;
      a = pt_lat - lat_i;
      b = lon_j - lon_i;
      c = lat_j - lat_i;
      d = pt_lon - lon_i;
      ab = a * b;
      cd = c * d;
      if (b > 0) return ab < cd;
      return cd < ab;
    endfunction

    // advance the polygon state with one accepted vertex word
    function void take_vertex(lat_t plat, lon_t plon, lat_t vlat, lon_t vlon, bit is_last);
      longint vla, vlo;
      vla = vlat;
      vlo = vlon;
      if (!open_poly) begin
        pt_lat = plat;
        pt_lon = plon;
        first_lat = vla;
        first_lon = vlo;
        prev_lat = vla;
        prev_lon = vlo;
        parity = 1'b0;
      end
      parity ^= edge_crosses(vla, vlo, prev_lat, prev_lon);
      if (is_last) begin
        // closing edge back to the first vertex
        parity ^= edge_crosses(first_lat, first_lon, vla, vlo);
        inside_q.push_back(parity);
        open_poly = 1'b0;
      end else begin
        prev_lat = vla;
        prev_lon = vlo;
        open_poly = 1'b1;
      end
    endfunction

    // compare one popped inside word with the oldest prediction
    function void check_inside(bit got);
      bit want;
      if (inside_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: inside word %0b popped with nothing predicted", got);
        return;
      end
      want = inside_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: inside_res expected %0b actual %0b", want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  lat_t in_point_lat = '0;
  lon_t in_point_lon = '0;
  lat_t in_vertex_lat = '0;
  lon_t in_vertex_lon = '0;
  logic in_last_vertex = 1'b0;
  logic out_pop = 1'b0;
  logic in_full;
  logic out_empty;
  logic out_inside_res;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_in_polygon_test #(
    .COORD_BITS(CB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_point_lat  (in_point_lat),
    .in_point_lon  (in_point_lon),
    .in_vertex_lat (in_vertex_lat),
    .in_vertex_lon (in_vertex_lon),
    .in_last_vertex(in_last_vertex),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_inside_res(out_inside_res)
  );

  geofence_scoreboard sb = new();

  // sender state; calm and hold_req also steer the receiver
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  lat_t poly_lat[$];
  lon_t poly_lon[$];

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  // offer one vertex word, maybe after a one-cycle idle, and wait until taken
  task automatic push_vertex(input lat_t plat, input lon_t plon, input lat_t vlat,
                             input lon_t vlon, input bit is_last);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_point_lat <= plat;
    in_point_lon <= plon;
    in_vertex_lat <= vlat;
    in_vertex_lon <= vlon;
    in_last_vertex <= is_last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.take_vertex(plat, plon, vlat, vlon, is_last);
    items_sent++;
  endtask

  // send the polygon held in poly_lat / poly_lon; later point fields are noise
  task automatic send_polygon(input lat_t plat, input lon_t plon);
    int n;
    n = poly_lat.size();
    for (int k = 0; k < n; k++) begin
      if (k == 0)
        push_vertex(plat, plon, poly_lat[k], poly_lon[k], n == 1);
      else
        push_vertex(lat_t'($urandom), lon_t'($urandom), poly_lat[k], poly_lon[k],
                    k == n - 1);
    end
  endtask

  // offset from the test point: exact hits, near misses and far vertices
  function automatic longint near_offset();
    longint s;
    case ($urandom_range(3))
      0: s = 3;
      1: s = 1000;
      2: s = 1000000;
      default: s = 400000000;
    endcase
    return longint'($urandom_range(0, 2 * s)) - s;
  endfunction

  // --------------------------------------------------------------------------
  // receiver: pop at random, hold off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_inside(out_inside_res);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    lat_t plat;
    lon_t plon;
    int mode, r, nv, holds, guard;
    holds = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single vertex polygon, then two vertex polygon over the point
    poly_lat = '{lat_t'(5)};
    poly_lon = '{lon_t'(5)};
    send_polygon(lat_t'(0), lon_t'(0));
    poly_lat = '{lat_t'(-10), lat_t'(-10)};
    poly_lon = '{lon_t'(-10), lon_t'(10)};
    send_polygon(lat_t'(0), lon_t'(0));

    // small square: inside, outside, on a vertex, on an edge
    poly_lat = '{lat_t'(-10), lat_t'(10), lat_t'(10), lat_t'(-10)};
    poly_lon = '{lon_t'(-10), lon_t'(-10), lon_t'(10), lon_t'(10)};
    send_polygon(lat_t'(0), lon_t'(0));
    send_polygon(lat_t'(100), lon_t'(100));
    send_polygon(lat_t'(10), lon_t'(10));
    send_polygon(lat_t'(10), lon_t'(0));

    // full bit-pattern extremes, point at center and at a corner
    poly_lat = '{LAT_BOT, LAT_TOP, LAT_TOP, LAT_BOT};
    poly_lon = '{LON_BOT, LON_BOT, LON_TOP, LON_TOP};
    send_polygon(lat_t'(0), lon_t'(0));
    send_polygon(LAT_TOP, LON_BOT);

    // range extremes of the coordinate system
    poly_lat = '{lat_t'(-LAT_SPAN), lat_t'(LAT_SPAN), lat_t'(LAT_SPAN), lat_t'(-LAT_SPAN)};
    poly_lon = '{lon_t'(-LON_SPAN), lon_t'(-LON_SPAN), lon_t'(LON_SPAN), lon_t'(LON_SPAN)};
    send_polygon(lat_t'(LAT_SPAN), lon_t'(-LON_SPAN));

    // random polygons
    while (items_sent < N_ITEMS) begin
      if ((holds == 0 && items_sent >= 150) || (holds == 1 && items_sent >= 900)) begin
        hold_req = 1'b1;
        holds++;
      end
      calm = (items_sent >= 500 && items_sent < 700);

      mode = $urandom_range(99);
      r = $urandom_range(99);
      nv = (r < 8) ? 1 : (r < 16) ? 2 : (r < 95) ? $urandom_range(3, 8) :
           $urandom_range(9, 24);
      if (mode < 15) begin
        plat = lat_t'($urandom);
        plon = lon_t'($urandom);
      end else begin
        plat = lat_t'(longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN);
        plon = lon_t'(longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
      end
      poly_lat.delete();
      poly_lon.delete();
      for (int k = 0; k < nv; k++) begin
        if (mode < 15) begin
          poly_lat.push_back(lat_t'($urandom));
          poly_lon.push_back(lon_t'($urandom));
        end else if (mode < 40) begin
          poly_lat.push_back(lat_t'(longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN));
          poly_lon.push_back(lon_t'(longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN));
        end else begin
          poly_lat.push_back(lat_t'(longint'(plat) + near_offset()));
          poly_lon.push_back(lon_t'(longint'(plon) + near_offset()));
        end
      end
      send_polygon(plat, plon);
    end
    calm = 1'b0;
    in_push <= 1'b0;

    // drain the result queue, then let the pipeline settle
    guard = 0;
    while (sb.inside_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.inside_q.size() != 0) begin
      $display("ERROR: %0d predicted inside words never arrived", sb.inside_q.size());
      sb.mismatches += sb.inside_q.size();
    end

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop in case a handshake hangs
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
